@@ sv/error_activity_signal_assert.svh @@
// Assertion macros shared by the error activity checker.
// No dependencies; included by files that assert.
`ifndef ERROR_ACTIVITY_SIGNAL_ASSERT_SVH
`define ERROR_ACTIVITY_SIGNAL_ASSERT_SVH

// Clocked assertion, muted while reset is held.
`define EAS_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define EAS_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ sv/eas_pkg.sv @@
// Constants, register indexes and the gaussian table for the error activity block.
// No dependencies.
package eas_pkg;

    localparam int ERROR_FRAC_BITS    = 12;
    localparam int DISCOUNT_FRAC_BITS = 24;
    localparam int GAUSS_DEPTH        = 256;
    localparam int GAUSS_IDX_W        = $clog2(GAUSS_DEPTH);

    localparam logic [1:0] CFG_DISCOUNT   = 2'd0;
    localparam logic [1:0] CFG_ALPHA_GAIN = 2'd1;
    localparam logic [1:0] CFG_BETA_GAIN  = 2'd2;
    localparam logic [1:0] CFG_ZERO_ALPHA = 2'd3;

    localparam logic [23:0] DISCOUNT_RST   = 24'd16775539;
    localparam logic [7:0]  ALPHA_GAIN_RST = 8'd100;
    localparam logic [7:0]  BETA_GAIN_RST  = 8'd25;
    localparam logic [23:0] ZERO_ALPHA_RST = 24'd409600;

    localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

    typedef logic [15:0] gauss_rom_t [GAUSS_DEPTH];

    // truncated quotient, one bit per step
    function automatic logic [63:0] udiv_q(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-(n + f/2^32)) in Q0.32, 64 bit wrap-around arithmetic
    function automatic logic [63:0] exp_neg_q32(logic [63:0] n, logic [63:0] f);
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] kk;
        acc  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (kk = 64'd1; kk <= 64'd24; kk++) begin
            term = udiv_q((term * f) >> 32, kk);
            if (kk[0]) begin
                acc = (term > acc) ? 64'd0 : acc - term;
            end else begin
                acc = acc + term;
            end
        end
        for (kk = 64'd0; kk < n; kk++) begin
            acc = (acc * EXP_M1_Q32) >> 32;
        end
        return acc;
    endfunction

    function automatic gauss_rom_t build_gauss();
        gauss_rom_t  rom;
        logic [63:0] num;
        logic [63:0] v;
        for (int i = 0; i < GAUSS_DEPTH; i++) begin
            num = 64'd32 * 64'(i) * 64'(i);
            v = (exp_neg_q32(num >> 16, (num & 64'hFFFF) << 16) + 64'd32768) >> 16;
            rom[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end
        return rom;
    endfunction

    localparam gauss_rom_t GAUSS_ROM = build_gauss();

endpackage

@@ sv/error_activity_signal.sv @@
// Top level of the error activity block: sequencer, shared divider and multiplier.
// Depends on eas_pkg.
//
// Usage
//   Input channel s_valid / s_ready / s_error_distance carries one distance
//   request (unsigned Q4.12). Output channel m_valid / m_ready / m_activity
//   carries one signed Q20.12 activity value per request.
//   Configuration: cfg_we writes cfg_data into the register cfg_index
//   (0 discount, 1 alpha gain, 2 beta gain, 3 zero-distance alpha); write
//   only while no request is in flight.
// Timing
//   A request is taken only in the idle state. The reciprocal runs on a
//   shared restoring divider, one quotient bit per cycle (skipped for a
//   zero distance); the activity is then registered once the output
//   register is free. Then the discounted sums (two sums) use a shared 32x24
//   multiplier, each in the steps add, low multiply, high multiply and
//   finish, then a saturation check and the mean division on the same
//   divider (skipped when saturated or the weight is zero).
// Reset
//   Clears sums and mean, loads register defaults, drops m_valid.
// Stall
//   A waiting result holds in the output register; the sequencer holds
//   before loading the next result until the receiver takes the old one.
module error_activity_signal (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_error_distance,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_activity,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV      = 4'd1;
    localparam logic [3:0] ST_ACT      = 4'd2;
    localparam logic [3:0] ST_SUM_ADD  = 4'd3;
    localparam logic [3:0] ST_MUL_LO   = 4'd4;
    localparam logic [3:0] ST_MUL_HI   = 4'd5;
    localparam logic [3:0] ST_SUM_FIN  = 4'd6;
    localparam logic [3:0] ST_MEAN_CHK = 4'd7;

    localparam logic [40:0] WT_MAX41   = {1'b0, {40{1'b1}}};
    localparam logic [64:0] WT_MAX65   = {25'd0, {40{1'b1}}};
    localparam logic [24:0] MEAN_MAX   = {25{1'b1}};
    localparam logic [4:0]  DIV_STEPS  = 5'd25;
    localparam int          BETA_SHIFT = 16 - eas_pkg::ERROR_FRAC_BITS;
    localparam int          DFB        = eas_pkg::DISCOUNT_FRAC_BITS;

    logic [3:0]  state_reg;
    logic [23:0] disc_reg;
    logic [7:0]  again_reg;
    logic [7:0]  bgain_reg;
    logic [23:0] zalpha_reg;

    logic [24:0] alpha_reg;
    logic [15:0] gauss_reg;
    logic [24:0] mean_reg;
    logic [63:0] ws_reg;
    logic [39:0] wt_reg;
    logic [63:0] sum_reg;
    logic [55:0] plo_reg;
    logic [55:0] phi_reg;
    logic        sel_wt_reg;

    logic [40:0] rem_reg;
    logic [39:0] dvs_reg;
    logic [24:0] quo_reg;
    logic        feed_reg;
    logic [4:0]  cnt_reg;
    logic        mean_div_reg;

    logic        m_valid_reg;
    logic [31:0] m_act_reg;

    // divider step
    logic [40:0] rem_shift;
    logic        rem_ge;
    logic [40:0] rem_next;
    logic [24:0] quo_next;

    // activity
    logic signed [25:0] diff;
    logic signed [34:0] aprod;
    logic [23:0]        bprod;
    logic signed [35:0] act_wide;
    logic [31:0]        act_sat;

    // sums
    logic [63:0] add_a;
    logic [63:0] add_b;
    logic [64:0] add_full;
    logic [63:0] add_sat;
    logic [31:0] mul_a;
    logic [55:0] mul_p;
    logic [64:0] fin_full;
    logic [63:0] ws_fin;
    logic [39:0] wt_fin;

    logic        out_free;
    logic [15:0] gauss_lookup;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_activity = m_act_reg;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        rem_shift = {rem_reg[39:0], feed_reg};
        rem_ge    = (rem_shift >= {1'b0, dvs_reg});
        rem_next  = rem_ge ? rem_shift - {1'b0, dvs_reg} : rem_shift;
        quo_next  = {quo_reg[23:0], rem_ge};
    end

    always_comb begin
        diff     = $signed({1'b0, alpha_reg}) - $signed({1'b0, mean_reg});
        aprod    = $signed({1'b0, again_reg}) * diff;
        bprod    = bgain_reg * gauss_reg;
        act_wide = 36'(aprod) + $signed({16'd0, bprod[23:BETA_SHIFT]});
        if (act_wide > 36'sd2147483647) begin
            act_sat = 32'h7FFF_FFFF;
        end else if (act_wide < -36'sd2147483648) begin
            act_sat = 32'h8000_0000;
        end else begin
            act_sat = act_wide[31:0];
        end
    end

    always_comb begin
        add_a    = sel_wt_reg ? (64'd1 << DFB) : {39'd0, alpha_reg};
        add_b    = sel_wt_reg ? {24'd0, wt_reg} : ws_reg;
        add_full = {1'b0, add_a} + {1'b0, add_b};
        if (sel_wt_reg) begin
            add_sat = (add_full > WT_MAX65) ? WT_MAX65[63:0] : add_full[63:0];
        end else begin
            add_sat = add_full[64] ? {64{1'b1}} : add_full[63:0];
        end
        mul_a    = (state_reg == ST_MUL_HI) ? sum_reg[63:32] : sum_reg[31:0];
        mul_p    = mul_a * disc_reg;
        fin_full = {1'b0, phi_reg, 8'd0} + {33'd0, plo_reg[55:DFB]};
        ws_fin   = fin_full[64] ? {64{1'b1}} : fin_full[63:0];
        wt_fin   = (fin_full > WT_MAX65) ? WT_MAX41[39:0] : fin_full[39:0];
    end

    // beyond the table end the gaussian is zero
    assign gauss_lookup = s_error_distance[15] ? 16'd0 :
        eas_pkg::GAUSS_ROM[s_error_distance[14:15-eas_pkg::GAUSS_IDX_W]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disc_reg   <= eas_pkg::DISCOUNT_RST;
            again_reg  <= eas_pkg::ALPHA_GAIN_RST;
            bgain_reg  <= eas_pkg::BETA_GAIN_RST;
            zalpha_reg <= eas_pkg::ZERO_ALPHA_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                eas_pkg::CFG_DISCOUNT:   disc_reg   <= cfg_data;
                eas_pkg::CFG_ALPHA_GAIN: again_reg  <= cfg_data[7:0];
                eas_pkg::CFG_BETA_GAIN:  bgain_reg  <= cfg_data[7:0];
                eas_pkg::CFG_ZERO_ALPHA: zalpha_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            ws_reg       <= 64'd0;
            wt_reg       <= 40'd0;
            mean_reg     <= 25'd0;
            sel_wt_reg   <= 1'b0;
            mean_div_reg <= 1'b0;
            cnt_reg      <= 5'd0;
        end else begin
            // drop a taken result unless a new one is loaded this cycle
            if (m_valid_reg && m_ready && !(state_reg == ST_ACT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        gauss_reg <= gauss_lookup;
                        if (s_error_distance == 16'd0) begin
                            alpha_reg <= {1'b0, zalpha_reg};
                            state_reg <= ST_ACT;
                        end else begin
                            // 2^24 / distance: feed a single one, then zeros
                            rem_reg      <= 41'd0;
                            feed_reg     <= 1'b1;
                            dvs_reg      <= {24'd0, s_error_distance};
                            cnt_reg      <= DIV_STEPS;
                            mean_div_reg <= 1'b0;
                            state_reg    <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    feed_reg <= 1'b0;
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1) begin
                        if (mean_div_reg) begin
                            mean_reg  <= quo_next;
                            state_reg <= ST_IDLE;
                        end else begin
                            alpha_reg <= quo_next;
                            state_reg <= ST_ACT;
                        end
                    end
                end
                ST_ACT: begin
                    // hold until the previous result is taken
                    if (out_free) begin
                        m_act_reg   <= act_sat;
                        m_valid_reg <= 1'b1;
                        sel_wt_reg  <= 1'b0;
                        state_reg   <= ST_SUM_ADD;
                    end
                end
                ST_SUM_ADD: begin
                    sum_reg   <= add_sat;
                    state_reg <= ST_MUL_LO;
                end
                ST_MUL_LO: begin
                    plo_reg   <= mul_p;
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    phi_reg   <= mul_p;
                    state_reg <= ST_SUM_FIN;
                end
                ST_SUM_FIN: begin
                    if (!sel_wt_reg) begin
                        ws_reg     <= ws_fin;
                        sel_wt_reg <= 1'b1;
                        state_reg  <= ST_SUM_ADD;
                    end else begin
                        wt_reg    <= wt_fin;
                        state_reg <= ST_MEAN_CHK;
                    end
                end
                ST_MEAN_CHK: begin
                    if (wt_reg == 40'd0) begin
                        mean_reg  <= 25'd0;
                        state_reg <= ST_IDLE;
                    end else if (ws_reg >= {23'd0, wt_reg, 1'b0}) begin
                        mean_reg  <= MEAN_MAX;
                        state_reg <= ST_IDLE;
                    end else begin
                        // sum below twice the weight: 25 quotient bits suffice
                        rem_reg      <= ws_reg[41:1];
                        feed_reg     <= ws_reg[0];
                        dvs_reg      <= wt_reg;
                        cnt_reg      <= DIV_STEPS;
                        mean_div_reg <= 1'b1;
                        state_reg    <= ST_DIV;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ sv/eas_checker.sv @@
// Port-level checker for error_activity_signal, bound to the top level.
// Depends on error_activity_signal_assert.svh.
`include "error_activity_signal_assert.svh"

module eas_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [15:0] s_error_distance,
    input logic        m_valid,
    input logic        m_ready,
    input logic signed [31:0] m_activity,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [23:0] cfg_data
);

    // a taken request closes the input after it
    `EAS_ASSERT_RST(a_busy_after_req, aclk, aresetn, s_valid && s_ready |=> !s_ready ##1 !s_ready)
    // a stalled result holds
    `EAS_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_activity))
    // reset leaves the block open with nothing to deliver
    `EAS_ASSERT_CLK(a_reset_state, aclk, !aresetn |=> s_ready && !m_valid)

endmodule

bind error_activity_signal eas_checker u_eas_checker (.*);

@@ dv/error_activity_signal_tb.sv @@
// Self-checking testbench for the error activity block: distance requests in,
// activity values out, compared against an in-bench predictor.
// Depends on eas_pkg and error_activity_signal.
`timescale 1ns / 1ps

module error_activity_signal_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_error_distance;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_activity;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    error_activity_signal u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_error_distance (s_error_distance),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_activity       (m_activity),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Predictor copy of the registers and the running statistics
    logic [23:0] pr_discount;
    logic [7:0]  pr_alpha_gain;
    logic [7:0]  pr_beta_gain;
    logic [23:0] pr_zero_alpha;
    logic [63:0] pr_wsum;
    logic [63:0] pr_wtotal;
    logic [63:0] pr_mean;
    logic [15:0] gauss_lut [256];

    logic signed [31:0] pending_activity [$];
    int                 n_fail;

    localparam logic [63:0] WSUM_LIMIT   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] WTOTAL_LIMIT = 64'h0000_00FF_FFFF_FFFF;
    localparam logic [63:0] MEAN_LIMIT   = 64'h0000_0000_01FF_FFFF;
    localparam logic [63:0] E_M1         = 64'd1580030169;

    typedef struct {
        logic [15:0]        distance;
        bit                 typed;
        logic signed [31:0] activity;
    } dist_row_t;

    // 4 ns clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // exp(-(n + f/2^32)) in Q0.32: truncated Taylor series, then n steps of e^-1
    function automatic logic [63:0] neg_exp_q32(logic [63:0] n, logic [63:0] f);
        logic [63:0] acc;
        logic [63:0] term;
        acc  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * f) >> 32) / 64'(k);
            if (k % 2 == 1) begin
                acc = (term > acc) ? 64'd0 : acc - term;
            end else begin
                acc = acc + term;
            end
        end
        for (longint j = 0; j < longint'(n); j++) begin
            acc = (acc * E_M1) >> 32;
        end
        return acc;
    endfunction

    function automatic logic [63:0] add_clamp(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] lim);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return (s > 65'(lim)) ? lim : s[63:0];
    endfunction

    function automatic logic [63:0] discount_clamp(logic [63:0] s, logic [23:0] d,
                                                   logic [63:0] lim);
        logic [127:0] p;
        p = (128'(s) * 128'(d)) >> 24;
        return (p > 128'(lim)) ? lim : p[63:0];
    endfunction

    // Expected activity for one distance; advances the predictor statistics
    function automatic logic signed [31:0] next_activity(logic [15:0] distance);
        logic [63:0]  alpha;
        logic [63:0]  gauss;
        logic [15:0]  idx;
        logic [127:0] q;
        longint       act;
        alpha = (distance == 16'd0) ? 64'(pr_zero_alpha) : (64'd1 << 24) / 64'(distance);
        idx   = distance >> 7;
        gauss = (idx < 16'd256) ? 64'(gauss_lut[idx[7:0]]) : 64'd0;
        act = longint'(pr_alpha_gain) * (longint'(alpha) - longint'(pr_mean))
            + longint'((64'(pr_beta_gain) * gauss) >> 4);
        if (act > 64'sd2147483647) act = 64'sd2147483647;
        if (act < -64'sd2147483648) act = -64'sd2147483648;
        pr_wsum   = discount_clamp(add_clamp(alpha, pr_wsum, WSUM_LIMIT),
                                   pr_discount, WSUM_LIMIT);
        pr_wtotal = discount_clamp(add_clamp(64'd1 << 24, pr_wtotal, WTOTAL_LIMIT),
                                   pr_discount, WTOTAL_LIMIT);
        if (pr_wtotal == 64'd0) begin
            pr_mean = 64'd0;
        end else begin
            q = (128'(pr_wsum) << 24) / 128'(pr_wtotal);
            pr_mean = (q > 128'(MEAN_LIMIT)) ? MEAN_LIMIT : q[63:0];
        end
        return act[31:0];
    endfunction

    // Present one request; hold valid and payload until it is taken
    task automatic send_distance(logic [15:0] distance, bit typed,
                                 logic signed [31:0] typed_act);
        logic signed [31:0] pred;
        s_valid          <= 1'b1;
        s_error_distance <= distance;
        do @(posedge aclk); while (!s_ready);
        pred = next_activity(distance);
        pending_activity.push_back(typed ? typed_act : pred);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            eas_pkg::CFG_DISCOUNT:   pr_discount   = val;
            eas_pkg::CFG_ALPHA_GAIN: pr_alpha_gain = val[7:0];
            eas_pkg::CFG_BETA_GAIN:  pr_beta_gain  = val[7:0];
            default:                 pr_zero_alpha = val;
        endcase
    endtask

    // Drop valid, let every expected value come back, then allow the pipeline to settle
    task automatic drain_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_activity.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [15:0] random_distance();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 16'($urandom);
        if (pick < 60) return 16'($urandom_range(1, 64));
        if (pick < 70) return 16'd0;
        if (pick < 85) return 16'($urandom_range(32768, 65535));
        return 16'($urandom_range(3800, 4400));
    endfunction

    // Receiver: stall pattern cycles through always-ready, light, periodic and heavy
    logic [15:0] rx_cycle = 16'd0;
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 16'd1;
        case (rx_cycle[8:7])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 2) != 0);
            2'd2:    m_ready <= rx_cycle[2];
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_activity.size() == 0) begin
                $error("activity: unexpected result %0d", m_activity);
                n_fail++;
            end else begin
                if (m_activity !== pending_activity[0]) begin
                    $error("activity: expected %0d, got %0d",
                           pending_activity[0], m_activity);
                    n_fail++;
                end
                void'(pending_activity.pop_front());
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        dist_row_t    rows [$];
        logic [63:0]  num;
        logic [63:0]  v;
        int           burst;
        int           gap;
        bit           no_gaps;
        logic [23:0]  disc;
        logic [7:0]   ag;
        logic [7:0]   bg;
        logic [23:0]  za;

        // Drive every input from time zero
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_error_distance = 16'd0;
        cfg_we           = 1'b0;
        cfg_index        = eas_pkg::CFG_DISCOUNT;
        cfg_data         = 24'd0;
        n_fail           = 0;

        for (int i = 0; i < 256; i++) begin
            num = 64'd32 * 64'(i) * 64'(i);
            v = (neg_exp_q32(num / 64'd65536, ((num % 64'd65536) << 32) / 64'd65536)
                 + 64'd32768) >> 16;
            gauss_lut[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end
        pr_discount   = 24'd16775539;
        pr_alpha_gain = 8'd100;
        pr_beta_gain  = 8'd25;
        pr_zero_alpha = 24'd409600;
        pr_wsum       = 64'd0;
        pr_wtotal     = 64'd0;
        pr_mean       = 64'd0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: zero distance straight after reset is
        // 100*409600 + (25*65535 >> 4), with the mean still zero
        rows.push_back('{16'd0, 1'b1, 32'sd41062398});
        rows.push_back('{16'd1, 1'b0, 32'sd0});          // largest reciprocal
        rows.push_back('{16'd65535, 1'b0, 32'sd0});      // largest distance, past table
        rows.push_back('{16'd4096, 1'b0, 32'sd0});       // distance one
        rows.push_back('{16'd32767, 1'b0, 32'sd0});      // last table entry
        rows.push_back('{16'd32768, 1'b0, 32'sd0});      // first index past the table
        rows.push_back('{16'd127, 1'b0, 32'sd0});
        rows.push_back('{16'd128, 1'b0, 32'sd0});
        rows.push_back('{16'd0, 1'b0, 32'sd0});
        rows.push_back('{16'd2, 1'b0, 32'sd0});
        rows.push_back('{16'hAAAA, 1'b0, 32'sd0});
        rows.push_back('{16'h5555, 1'b0, 32'sd0});
        rows.push_back('{16'd8192, 1'b0, 32'sd0});
        rows.push_back('{16'd3, 1'b0, 32'sd0});
        rows.push_back('{16'd0, 1'b0, 32'sd0});
        foreach (rows[r]) begin
            send_distance(rows[r].distance, rows[r].typed, rows[r].activity);
        end
        drain_block();

        // Phases: each rewrites every register, then sends random requests
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin disc = 24'd0; ag = 8'd255; bg = 8'd255; za = 24'hFFFFFF; end
                1: begin disc = 24'hFFFFFF; ag = 8'd0; bg = 8'd0; za = 24'd0; end
                2: begin disc = 24'hFFFFFF; ag = 8'd255; bg = 8'd255; za = 24'hFFFFFF; end
                default: begin
                    disc = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(16000000, 16777215))
                                                       : 24'($urandom);
                    ag = 8'($urandom);
                    bg = 8'($urandom);
                    za = 24'($urandom);
                end
            endcase
            write_reg(eas_pkg::CFG_DISCOUNT, disc);
            write_reg(eas_pkg::CFG_ALPHA_GAIN, {16'd0, ag});
            write_reg(eas_pkg::CFG_BETA_GAIN, {16'd0, bg});
            write_reg(eas_pkg::CFG_ZERO_ALPHA, za);

            no_gaps = (ph % 3 == 1);
            burst = 0;
            for (int n = 0; n < 170; n++) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 8);
                    gap = no_gaps ? 0 : $urandom_range(0, 5);
                    if (gap > 0) begin
                        s_valid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end
                send_distance(random_distance(), 1'b0, 32'sd0);
                burst--;
            end
            drain_block();
        end

        if (n_fail == 0 && pending_activity.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/eas_pkg.sv
sv/error_activity_signal.sv
sv/eas_checker.sv
dv/error_activity_signal_tb.sv
